// File: rtl/core/rgbfill_pkg.sv
// Shared types and constants for the RGB565 frame store fill engine.
`timescale 1ns / 1ps

package rgbfill_pkg;

    localparam int MAX_WIDTH   = 320;
    localparam int MAX_HEIGHT  = 240;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int PIXEL_W = 16;
    localparam int COORD_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] CMD_FILL_ALL  = 2'd0;
    localparam logic [1:0] CMD_SET_PIXEL = 2'd1;
    localparam logic [1:0] CMD_FILL_RECT = 2'd2;
    localparam logic [1:0] CMD_READ_PIX  = 2'd3;

    localparam logic [COL_W-1:0] RESET_WIDTH  = COL_W'(320);
    localparam logic [ROW_W-1:0] RESET_HEIGHT = ROW_W'(240);

    typedef enum logic [1:0]
    {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef struct packed
    {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] rect_w;
        logic [COORD_W-1:0] rect_h;
        logic [PIXEL_W-1:0] pixel_color;
    } in_item_t;

    typedef struct packed
    {
        logic [PIXEL_W-1:0] read_data;
        logic               in_bounds;
    } out_item_t;

    typedef struct packed
    {
        op_t                op;
        logic               ok;
        logic [COL_W-1:0]   x_first;
        logic [COL_W-1:0]   x_last;
        logic [ROW_W-1:0]   y_first;
        logic [ROW_W-1:0]   y_last;
        logic [COL_W-1:0]   stride;
        logic [PIXEL_W-1:0] color;
    } desc_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: rtl/core/rgb565_framebuffer_fill_engine_core.sv
// Top level of the RGB565 frame store fill engine.
//
// Commands arrive on in_valid/in_stall/in_data; each gives exactly one result transfer
// on out_valid/out_stall/out_data (read_data, in_bounds). Geometry registers sit on the
// APB port: active_width at 0x0, active_height at 0x4; write them only while idle.
// The decode front end accepts a command per cycle, unless in_stall is high, into a
// two-entry descriptor queue; the back end works through one descriptor at a time
// against a single-write-port store. Per command the back end steps from idle through
// setup, then writes each pixel in turn in the walk state (set pixel, fills), or reads
// and waits for the store read (read pixel), or goes straight to done (empty or
// rejected command); done loads the result register. After reset the back end
// sweeps all MAX_WIDTH*MAX_HEIGHT (76800) store words to zero, one word per cycle;
// in_stall stays high during the sweep. When the receiver holds out_stall, the finished
// result waits in the output register; the back end stops before delivering the next
// result, the queue fills, then in_stall rises.
`timescale 1ns / 1ps

module rgb565_framebuffer_fill_engine_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgbfill_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rgbfill_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rgbfill_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rgbfill_pkg::in_item_t               in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output rgbfill_pkg::out_item_t              out_data
);

    rgbfill_pkg::queue_status_t        q_status;
    rgbfill_pkg::desc_t                q_wdata;
    rgbfill_pkg::desc_t                q_rdata;
    logic                              q_push;
    logic                              q_pop;
    logic                              clearing;
    logic                              ram_wr_en;
    logic [rgbfill_pkg::ADDR_W-1:0]    ram_wr_addr;
    logic [rgbfill_pkg::PIXEL_W-1:0]   ram_wr_data;
    logic                              ram_rd_en;
    logic [rgbfill_pkg::ADDR_W-1:0]    ram_rd_addr;
    logic [rgbfill_pkg::PIXEL_W-1:0]   ram_rd_data;

    rgbfill_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .clearing (clearing),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    rgbfill_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    rgbfill_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    rgbfill_ram #(
        .WIDTH (rgbfill_pkg::PIXEL_W),
        .DEPTH (rgbfill_pkg::STORE_DEPTH)
    ) u_store
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// File: rtl/core/rgbfill_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rgbfill_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: rtl/core/rgbfill_front.sv
// Front end: geometry registers, command accept and decode into write/read descriptors.
`timescale 1ns / 1ps

module rgbfill_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgbfill_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rgbfill_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rgbfill_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rgbfill_pkg::in_item_t               in_data,
    input  logic                                clearing,
    input  rgbfill_pkg::queue_status_t          q_status,
    output logic                                q_push,
    output rgbfill_pkg::desc_t                  q_wdata
);

    logic [rgbfill_pkg::COL_W-1:0] width_reg;
    logic [rgbfill_pkg::ROW_W-1:0] height_reg;
    logic [rgbfill_pkg::COL_W-1:0] wid;
    logic [rgbfill_pkg::ROW_W-1:0] hei;
    logic                          in_area;
    logic [rgbfill_pkg::COORD_W:0] x_sum;
    logic [rgbfill_pkg::COORD_W:0] y_sum;
    logic [rgbfill_pkg::COL_W-1:0] x_end;
    logic [rgbfill_pkg::ROW_W-1:0] y_end;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgbfill_pkg::RESET_WIDTH;
            height_reg <= rgbfill_pkg::RESET_HEIGHT;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == rgbfill_pkg::REG_HEIGHT)
            begin
                height_reg <= pwdata[rgbfill_pkg::ROW_W-1:0];
            end
            else
            begin
                width_reg <= pwdata[rgbfill_pkg::COL_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == rgbfill_pkg::REG_HEIGHT)
        begin
            prdata = rgbfill_pkg::APB_DATA_W'(height_reg);
        end
        else
        begin
            prdata = rgbfill_pkg::APB_DATA_W'(width_reg);
        end
    end

    // effective geometry saturates at the store size
    assign wid = (int'(width_reg) > rgbfill_pkg::MAX_WIDTH) ?
                 rgbfill_pkg::COL_W'(rgbfill_pkg::MAX_WIDTH) : width_reg;
    assign hei = (int'(height_reg) > rgbfill_pkg::MAX_HEIGHT) ?
                 rgbfill_pkg::ROW_W'(rgbfill_pkg::MAX_HEIGHT) : height_reg;

    assign in_area = (in_data.pos_x < rgbfill_pkg::COORD_W'(wid)) &&
                     (in_data.pos_y < rgbfill_pkg::COORD_W'(hei));

    assign x_sum = {1'b0, in_data.pos_x} + {1'b0, in_data.rect_w};
    assign y_sum = {1'b0, in_data.pos_y} + {1'b0, in_data.rect_h};
    assign x_end = (x_sum > (rgbfill_pkg::COORD_W + 1)'(wid)) ?
                   wid : x_sum[rgbfill_pkg::COL_W-1:0];
    assign y_end = (y_sum > (rgbfill_pkg::COORD_W + 1)'(hei)) ?
                   hei : y_sum[rgbfill_pkg::ROW_W-1:0];

    always_comb
    begin
        q_wdata         = '0;
        q_wdata.op      = rgbfill_pkg::OP_NONE;
        q_wdata.ok      = 1'b0;
        q_wdata.x_first = in_data.pos_x[rgbfill_pkg::COL_W-1:0];
        q_wdata.x_last  = in_data.pos_x[rgbfill_pkg::COL_W-1:0];
        q_wdata.y_first = in_data.pos_y[rgbfill_pkg::ROW_W-1:0];
        q_wdata.y_last  = in_data.pos_y[rgbfill_pkg::ROW_W-1:0];
        q_wdata.stride  = wid;
        q_wdata.color   = in_data.pixel_color;
        case (in_data.cmd)
            rgbfill_pkg::CMD_FILL_ALL:
            begin
                q_wdata.x_first = '0;
                q_wdata.y_first = '0;
                q_wdata.x_last  = wid - 1'b1;
                q_wdata.y_last  = hei - 1'b1;
                if ((wid != '0) && (hei != '0))
                begin
                    q_wdata.op = rgbfill_pkg::OP_WRITE;
                    q_wdata.ok = 1'b1;
                end
            end
            rgbfill_pkg::CMD_SET_PIXEL:
            begin
                if (in_area)
                begin
                    q_wdata.op = rgbfill_pkg::OP_WRITE;
                    q_wdata.ok = 1'b1;
                end
            end
            rgbfill_pkg::CMD_FILL_RECT:
            begin
                if (in_area)
                begin
                    q_wdata.ok     = 1'b1;
                    q_wdata.x_last = x_end - 1'b1;
                    q_wdata.y_last = y_end - 1'b1;
                    if ((in_data.rect_w != '0) && (in_data.rect_h != '0))
                    begin
                        q_wdata.op = rgbfill_pkg::OP_WRITE;
                    end
                end
            end
            rgbfill_pkg::CMD_READ_PIX:
            begin
                if (in_area)
                begin
                    q_wdata.op = rgbfill_pkg::OP_READ;
                    q_wdata.ok = 1'b1;
                end
            end
            default:
            begin
                q_wdata.op = rgbfill_pkg::OP_NONE;
            end
        endcase
    end

    assign in_stall = q_status.full | clearing;
    assign q_push   = in_valid & ~in_stall;

endmodule

// File: rtl/core/rgbfill_queue.sv
// Short descriptor queue between the decode front end and the store back end.
`timescale 1ns / 1ps

module rgbfill_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  rgbfill_pkg::desc_t         wdata,
    input  logic                       pop,
    output rgbfill_pkg::desc_t         rdata,
    output rgbfill_pkg::queue_status_t status
);

    rgbfill_pkg::desc_t                entry_reg [rgbfill_pkg::QUEUE_DEPTH];
    logic [rgbfill_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [rgbfill_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [rgbfill_pkg::QCNT_W-1:0]    count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign status.full  = (count_reg == rgbfill_pkg::QCNT_W'(rgbfill_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign rdata        = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == rgbfill_pkg::QPTR_W'(rgbfill_pkg::QUEUE_DEPTH - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == rgbfill_pkg::QPTR_W'(rgbfill_pkg::QUEUE_DEPTH - 1))
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/rgbfill_back.sv
// Back end: post-reset clear, pixel walker, store read and result register.
`timescale 1ns / 1ps

module rgbfill_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rgbfill_pkg::queue_status_t         q_status,
    input  rgbfill_pkg::desc_t                 q_rdata,
    output logic                               q_pop,
    output logic                               clearing,
    output logic                               ram_wr_en,
    output logic [rgbfill_pkg::ADDR_W-1:0]     ram_wr_addr,
    output logic [rgbfill_pkg::PIXEL_W-1:0]    ram_wr_data,
    output logic                               ram_rd_en,
    output logic [rgbfill_pkg::ADDR_W-1:0]     ram_rd_addr,
    input  logic [rgbfill_pkg::PIXEL_W-1:0]    ram_rd_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output rgbfill_pkg::out_item_t             out_data
);

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    localparam int PROD_W = rgbfill_pkg::COL_W + rgbfill_pkg::ROW_W;

    state_t                            state_reg;
    rgbfill_pkg::desc_t                cur_reg;
    logic [rgbfill_pkg::COL_W-1:0]     x_reg;
    logic [rgbfill_pkg::ROW_W-1:0]     y_reg;
    logic [rgbfill_pkg::ADDR_W-1:0]    row_base_reg;
    logic [rgbfill_pkg::ADDR_W-1:0]    clr_addr_reg;
    logic [rgbfill_pkg::PIXEL_W-1:0]   data_reg;
    logic                              out_valid_reg;
    rgbfill_pkg::out_item_t            out_data_reg;
    logic [PROD_W-1:0]                 row_prod;
    logic [rgbfill_pkg::ADDR_W-1:0]    pixel_addr;

    assign row_prod   = PROD_W'(cur_reg.y_first) * PROD_W'(cur_reg.stride);
    assign pixel_addr = row_base_reg + rgbfill_pkg::ADDR_W'(x_reg);

    assign clearing    = (state_reg == ST_CLEAR);
    assign q_pop       = (state_reg == ST_IDLE) && !q_status.empty;
    assign ram_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_WALK);
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : pixel_addr;
    assign ram_wr_data = (state_reg == ST_CLEAR) ? '0 : cur_reg.color;
    assign ram_rd_en   = (state_reg == ST_READ);
    assign ram_rd_addr = pixel_addr;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            row_base_reg  <= '0;
            clr_addr_reg  <= '0;
            data_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg ==
                        rgbfill_pkg::ADDR_W'(rgbfill_pkg::STORE_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        cur_reg   <= q_rdata;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    row_base_reg <= rgbfill_pkg::ADDR_W'(row_prod);
                    x_reg        <= cur_reg.x_first;
                    y_reg        <= cur_reg.y_first;
                    data_reg     <= '0;
                    case (cur_reg.op)
                        rgbfill_pkg::OP_WRITE: state_reg <= ST_WALK;
                        rgbfill_pkg::OP_READ:  state_reg <= ST_READ;
                        default:               state_reg <= ST_DONE;
                    endcase
                end
                ST_WALK:
                begin
                    if (x_reg == cur_reg.x_last)
                    begin
                        if (y_reg == cur_reg.y_last)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            y_reg        <= y_reg + 1'b1;
                            x_reg        <= cur_reg.x_first;
                            row_base_reg <= row_base_reg +
                                            rgbfill_pkg::ADDR_W'(cur_reg.stride);
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + 1'b1;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_READ_WAIT;
                end
                ST_READ_WAIT:
                begin
                    data_reg  <= ram_rd_data;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_data_reg.read_data <= data_reg;
                        out_data_reg.in_bounds <= cur_reg.ok;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the RGB565 frame store fill engine.
`timescale 1ns / 1ps

module tb;

    import rgbfill_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam int N_PHASES    = 11;
    localparam int PHASE_ITEMS = 145;

    typedef struct
    {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;

    bit [PIXEL_W-1:0] frame_mirror [STORE_DEPTH];
    logic [COL_W-1:0] cfg_w = RESET_WIDTH;
    logic [ROW_W-1:0] cfg_h = RESET_HEIGHT;

    out_item_t   due_results [$];
    stim_row_t   dir_tab [$];
    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_hold     = 0;
    bit          idle_on     = 1'b1;

    int unsigned geo_w [N_PHASES] = '{8, 1, 0, 12, 511, 320, 1, 17, 3, 300, 320};
    int unsigned geo_h [N_PHASES] = '{6, 1, 9, 0, 255, 1, 240, 13, 200, 3, 240};

    rgb565_framebuffer_fill_engine_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned eff_cols();
        return (cfg_w > MAX_WIDTH) ? MAX_WIDTH : cfg_w;
    endfunction

    function automatic int unsigned eff_rows();
        return (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h;
    endfunction

    function automatic out_item_t predict_frame_cmd(in_item_t c);
        int unsigned wid;
        int unsigned hei;
        int unsigned xe;
        int unsigned ye;
        int unsigned px;
        int unsigned py;
        int unsigned i;
        bit          in_area;
        out_item_t   r;
        wid     = eff_cols();
        hei     = eff_rows();
        in_area = (c.pos_x < wid) && (c.pos_y < hei);
        r       = '0;
        case (c.cmd)
            CMD_FILL_ALL:
            begin
                for (i = 0; i < wid * hei; i++)
                    frame_mirror[i] = c.pixel_color;
                r.in_bounds = (wid * hei != 0);
            end
            CMD_SET_PIXEL:
            begin
                if (in_area)
                begin
                    frame_mirror[c.pos_y * wid + c.pos_x] = c.pixel_color;
                    r.in_bounds = 1'b1;
                end
            end
            CMD_FILL_RECT:
            begin
                if (in_area)
                begin
                    // far edges summed wide, then clipped
                    xe = 32'(c.pos_x) + 32'(c.rect_w);
                    ye = 32'(c.pos_y) + 32'(c.rect_h);
                    if (xe > wid)
                        xe = wid;
                    if (ye > hei)
                        ye = hei;
                    for (py = c.pos_y; py < ye; py++)
                        for (px = c.pos_x; px < xe; px++)
                            frame_mirror[py * wid + px] = c.pixel_color;
                    r.in_bounds = 1'b1;
                end
            end
            CMD_READ_PIX:
            begin
                if (in_area)
                begin
                    r.read_data = frame_mirror[c.pos_y * wid + c.pos_x];
                    r.in_bounds = 1'b1;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic stim_row_t mk_row(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] w, logic [15:0] h, logic [15:0] color,
                                         bit typed, logic [15:0] rd, logic ib);
        stim_row_t s;
        s.item.cmd         = cmd;
        s.item.pos_x       = x;
        s.item.pos_y       = y;
        s.item.rect_w      = w;
        s.item.rect_h      = h;
        s.item.pixel_color = color;
        s.typed            = typed;
        s.want.read_data   = rd;
        s.want.in_bounds   = ib;
        return s;
    endfunction

    function automatic logic [15:0] draw_coord(int unsigned lim);
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'(lim);
            default: return 16'($urandom_range(0, (lim == 0) ? 0 : lim - 1));
        endcase
    endfunction

    function automatic in_item_t draw_cmd();
        in_item_t    c;
        int unsigned pick;
        bit          cheap;
        cheap         = (eff_cols() * eff_rows() <= 1024);
        pick          = $urandom_range(0, 99);
        c.pixel_color = 16'($urandom);
        c.pos_x       = draw_coord(eff_cols());
        c.pos_y       = draw_coord(eff_rows());
        if (cheap && $urandom_range(0, 7) == 0)
        begin
            c.rect_w = 16'($urandom);
            c.rect_h = 16'($urandom);
        end
        else
        begin
            c.rect_w = 16'($urandom_range(0, cheap ? 8 : 12));
            c.rect_h = 16'($urandom_range(0, cheap ? 8 : 12));
        end
        if (cheap && pick < 8)
            c.cmd = CMD_FILL_ALL;
        else if (pick < 38)
            c.cmd = CMD_SET_PIXEL;
        else if (pick < 62)
            c.cmd = CMD_FILL_RECT;
        else
            c.cmd = CMD_READ_PIX;
        return c;
    endfunction

    task automatic send_item(in_item_t c, bit typed, out_item_t want);
        out_item_t r;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= c;
        do
            @(posedge clk);
        while (in_stall);
        r = predict_frame_cmd(c);
        due_results.push_back(typed ? want : r);
    endtask

    task automatic pause_sender(int unsigned n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained(int unsigned tail);
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_geometry(logic idx, logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_WIDTH) ? 32'h1FF : 32'hFF;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) != (value & mask))
        begin
            $display("%0t register %0d readback: expected %h actual %h",
                     $time, idx, value & mask, prdata & mask);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_WIDTH)
            cfg_w = value[COL_W-1:0];
        else
            cfg_h = value[ROW_W-1:0];
    endtask

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            rx_hold   = 0;
            out_stall <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            rx_hold   = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t unexpected transfer: expected none actual %h/%b",
                         $time, out_data.read_data, out_data.in_bounds);
                fail_count++;
            end
            else
            begin
                exp_r = due_results.pop_front();
                if (out_data.read_data !== exp_r.read_data)
                begin
                    $display("%0t read_data: expected %h actual %h",
                             $time, exp_r.read_data, out_data.read_data);
                    fail_count++;
                end
                if (out_data.in_bounds !== exp_r.in_bounds)
                begin
                    $display("%0t in_bounds: expected %b actual %b",
                             $time, exp_r.in_bounds, out_data.in_bounds);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned ph;
        int unsigned k;
        out_item_t   none;
        none      = '0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;

        dir_tab.push_back(mk_row(CMD_READ_PIX,  0,   0,   0, 0, 16'h0000, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  319, 239, 0, 0, 16'h0000, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  320, 0,   0, 0, 16'h0000, 1, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  0,   240, 0, 0, 16'h0000, 1, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 1, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_SET_PIXEL, 319, 239, 0, 0, 16'hFFFF, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  319, 239, 0, 0, 16'h0000, 1, 16'hFFFF, 1));
        dir_tab.push_back(mk_row(CMD_SET_PIXEL, 320, 5,   0, 0, 16'h1111, 1, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_SET_PIXEL, 0, 16'hFFFF, 0, 0, 16'h2222, 1, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_FILL_RECT, 320, 0,   4, 4, 16'h3333, 1, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_FILL_RECT, 0,   240, 4, 4, 16'h4444, 1, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_FILL_RECT, 0,   0,   0, 5, 16'hABCD, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_FILL_RECT, 10,  10,  5, 0, 16'hABCD, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_FILL_RECT, 315, 235, 16'hFFFF, 16'hFFFF,
                                 16'h1234, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  319, 239, 0, 0, 16'h0000, 1, 16'h1234, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  314, 235, 0, 0, 16'h0000, 0, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_FILL_RECT, 0,   0,   3, 2, 16'hF800, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  2,   1,   0, 0, 16'h0000, 1, 16'hF800, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  3,   1,   0, 0, 16'h0000, 0, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  10,  10,  0, 0, 16'h0000, 0, 16'h0000, 0));
        dir_tab.push_back(mk_row(CMD_FILL_ALL,  0,   0,   0, 0, 16'h07E0, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  160, 120, 0, 0, 16'h0000, 1, 16'h07E0, 1));
        dir_tab.push_back(mk_row(CMD_SET_PIXEL, 0,   0,   0, 0, 16'h0000, 1, 16'h0000, 1));
        dir_tab.push_back(mk_row(CMD_READ_PIX,  0,   0,   0, 0, 16'h0000, 1, 16'h0000, 1));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            wait_drained(8);
            write_geometry(REG_WIDTH, geo_w[ph]);
            write_geometry(REG_HEIGHT, geo_h[ph]);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == N_PHASES - 1)
                    idle_on = 1'b0;
                else if (k % 32 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                if (k == PHASE_ITEMS / 2)
                    wait_drained(0);
                if (idle_on && $urandom_range(0, 7) == 0)
                    pause_sender($urandom_range(1, 17));
                send_item(draw_cmd(), 1'b0, none);
            end
        end

        wait_drained(20);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
